[rtl/iowr_pkg.sv]
// ----------------------------------------------------------------------------
// iowr_pkg
// Shared types and constants of the I/O window range table.
// ----------------------------------------------------------------------------
package iowr_pkg;

  localparam int unsigned IOWR_NUM_RANGES = 8;
  localparam logic [32:0] IOWR_FALLBACK_SIZE = 33'h0_0001_0000;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned SIZE_W  = 33;
  localparam int unsigned PORT_W  = 32;
  // Sum of stored sizes never passes 2^32; one extra bit keeps compares safe.
  localparam int unsigned ALLOC_W = 34;

  localparam logic [31:0] LIMIT_RESET = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    REQ_REG = 2'd0,
    REQ_P2A = 2'd1,
    REQ_A2P = 2'd2,
    REQ_NOP = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PRESENT    = 3'd1,
    ST_ZERO_SIZE  = 3'd2,
    ST_LEGACY_NOSP = 3'd3,
    ST_TOO_BIG    = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  typedef enum logic {
    CFG_LIMIT  = 1'b0,
    CFG_LEGACY = 1'b1
  } cfg_index_t;

  // Request token that walks the row of cells.
  typedef struct packed {
    logic                 valid;
    req_type_t            req_type;
    logic [ADDR_W-1:0]    addr;
    logic [SIZE_W-1:0]    size;
    logic [PORT_W-1:0]    pio;
    logic [ALLOC_W-1:0]   alloc;
    logic                 hit;
    logic [ADDR_W-1:0]    res_addr;
    logic [PORT_W-1:0]    res_port;
  } token_t;

  // Write of one table entry from the finish stage.
  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    start;
    logic [SIZE_W-1:0]    size;
  } tbl_wr_t;

endpackage

[rtl/iowr_cell.sv]
// ----------------------------------------------------------------------------
// iowr_cell
// One table entry: holds a window and tests the passing request token.
// ----------------------------------------------------------------------------
module iowr_cell
  import iowr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              active,
  input  logic [ADDR_W-1:0] legacy_addr,
  input  tbl_wr_t           wr,
  input  token_t            tok_in,
  output token_t            tok_out
);

  logic [ADDR_W-1:0]  start;
  logic [SIZE_W-1:0]  wsize;

  token_t             tok_next;
  logic               hit_now;
  logic               is_legacy;
  logic [ADDR_W:0]    win_end;
  logic [ADDR_W:0]    req_end;
  logic [ALLOC_W-1:0] alloc_end;
  logic [ALLOC_W-1:0] pio_x;
  logic [ALLOC_W-1:0] pio_off;
  logic [ADDR_W-1:0]  addr_off;

  always_comb begin
    is_legacy = (start == legacy_addr);
    win_end   = {1'b0, start} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, wsize};
    req_end   = {1'b0, tok_in.addr} + {{(ADDR_W + 1 - SIZE_W){1'b0}}, tok_in.size};
    alloc_end = tok_in.alloc + {{(ALLOC_W - SIZE_W){1'b0}}, wsize};
    pio_x     = {{(ALLOC_W - PORT_W){1'b0}}, tok_in.pio};
    pio_off   = pio_x - tok_in.alloc;
    addr_off  = tok_in.addr - start;
  end

  always_comb begin
    tok_next = tok_in;
    hit_now  = 1'b0;
    if (tok_in.valid && active && !tok_in.hit) begin
      case (tok_in.req_type)
        REQ_REG: begin
          if (tok_in.addr >= start && req_end <= win_end) begin
            hit_now           = 1'b1;
            tok_next.res_port = tok_in.alloc[PORT_W-1:0];
          end
        end
        REQ_P2A: begin
          if (!is_legacy && pio_x >= tok_in.alloc && pio_x < alloc_end) begin
            hit_now           = 1'b1;
            tok_next.res_addr = start + {{(ADDR_W - PORT_W){1'b0}}, pio_off[PORT_W-1:0]};
          end
        end
        REQ_A2P: begin
          if (!is_legacy && tok_in.addr >= start &&
              {1'b0, tok_in.addr} < win_end) begin
            hit_now           = 1'b1;
            tok_next.res_port = addr_off[PORT_W-1:0] + tok_in.alloc[PORT_W-1:0];
          end
        end
        default: begin
          hit_now = 1'b0;
        end
      endcase
      tok_next.hit = hit_now;
      // Advance the running port base past this window on a miss.
      if (!hit_now) begin
        tok_next.alloc = alloc_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start <= wr.start;
      wsize <= wr.size;
    end
  end

endmodule

[rtl/io_window_range_table_top.sv]
// ----------------------------------------------------------------------------
// io_window_range_table_top
// Ordered table of physical I/O windows packed into one port-number space.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type, phys_addr, win_size, port_num
// rsp       out        rsp_valid/rsp_stall   status, found, addr_out, port_out
// cfg       in         cfg_we                cfg_index, cfg_data
//
// Flow: an accepted request is registered as a token that walks the row of
//   NUM_RANGES cells, one cell per cycle, then waits in the finish stage until
//   the output register frees; the next request is taken only after the
//   previous one has left the finish stage.
// Reset: rst clears the entry count, the legacy flag and address, busy and all
//   valid flags and sets port_limit to LIMIT_RESET; entries hold garbage until written.
// Stalls: req_stall is high while a request is in the cell row or the
//   finish stage; a result stalled in the output register does not block
//   the next request from entering the row.
//
module io_window_range_table_top
  import iowr_pkg::*;
#(
  parameter int unsigned NUM_RANGES    = IOWR_NUM_RANGES,
  parameter logic [32:0] FALLBACK_SIZE = IOWR_FALLBACK_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  // request transaction
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          req_type,
  input  logic [ADDR_W-1:0]   phys_addr,
  input  logic [SIZE_W-1:0]   win_size,
  input  logic [PORT_W-1:0]   port_num,
  // result transaction
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [2:0]          status,
  output logic                found,
  output logic [ADDR_W-1:0]   addr_out,
  output logic [PORT_W-1:0]   port_out,
  // configuration writes
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int unsigned CNT_W = $clog2(NUM_RANGES + 1);

  // Configuration registers.
  logic [PORT_W-1:0] port_limit;
  logic [ADDR_W-1:0] legacy_addr;

  // Table bookkeeping.
  logic [CNT_W-1:0]  count;
  logic              legacy_present;
  logic              busy;

  // Token chain: tok[0] feeds cell 0, tok[i+1] is the output of cell i.
  token_t            tok [NUM_RANGES+1];
  token_t            launch;
  token_t            fin;
  logic              req_accept;
  logic              fin_drain;
  tbl_wr_t           tbl_wr;

  // Finish-stage decisions.
  status_t           st_next;
  logic              found_next;
  logic [ADDR_W-1:0] addr_next;
  logic [PORT_W-1:0] port_next;
  logic              is_legacy_req;
  logic [ALLOC_W:0]  need_end;
  logic [ALLOC_W:0]  fb_end;
  logic              over_req;
  logic              over_fb;

  assign req_stall  = busy;
  assign req_accept = req_valid && !busy;
  assign fin_drain  = fin.valid && (!rsp_valid || !rsp_stall);

  // -------------------------------------------------------------------------
  // Configuration
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      port_limit  <= LIMIT_RESET;
      legacy_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LIMIT:  port_limit  <= cfg_data[PORT_W-1:0];
        CFG_LEGACY: legacy_addr <= cfg_data;
        default:    port_limit  <= port_limit;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Request entry: launch a fresh token into the cell row
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      launch.valid <= 1'b0;
    end else begin
      launch.valid    <= req_accept;
      launch.req_type <= req_type_t'(req_type);
      launch.addr     <= phys_addr;
      launch.size     <= win_size;
      launch.pio      <= port_num;
      launch.alloc    <= '0;
      launch.hit      <= 1'b0;
      launch.res_addr <= '0;
      launch.res_port <= '0;
    end
  end

  assign tok[0] = launch;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_accept) begin
      busy <= 1'b1;
    end else if (fin_drain) begin
      busy <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Row of cells, one per table entry
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < NUM_RANGES; i++) begin : g_cell
    tbl_wr_t cell_wr;
    logic    cell_active;

    always_comb begin
      cell_active  = (CNT_W'(i) < count);
      cell_wr      = tbl_wr;
      cell_wr.en   = tbl_wr.en && (count == CNT_W'(i));
    end

    iowr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .active      (cell_active),
      .legacy_addr (legacy_addr),
      .wr          (cell_wr),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  // -------------------------------------------------------------------------
  // Finish stage: hold the token that left the row until the output frees
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else if (tok[NUM_RANGES].valid) begin
      fin <= tok[NUM_RANGES];
    end else if (fin_drain) begin
      fin.valid <= 1'b0;
    end
  end

  always_comb begin
    is_legacy_req = (fin.addr == legacy_addr);
    need_end = {1'b0, fin.alloc} + {{(ALLOC_W + 1 - SIZE_W){1'b0}}, fin.size}
               - {{ALLOC_W{1'b0}}, 1'b1};
    fb_end   = {1'b0, fin.alloc} + {{(ALLOC_W + 1 - SIZE_W){1'b0}}, FALLBACK_SIZE}
               - {{ALLOC_W{1'b0}}, 1'b1};
    over_req = need_end > {{(ALLOC_W + 1 - PORT_W){1'b0}}, port_limit};
    over_fb  = fb_end   > {{(ALLOC_W + 1 - PORT_W){1'b0}}, port_limit};
  end

  always_comb begin
    st_next    = ST_OK;
    found_next = 1'b0;
    addr_next  = '1;
    port_next  = '0;
    tbl_wr.en    = 1'b0;
    tbl_wr.start = fin.addr;
    tbl_wr.size  = fin.size;
    case (fin.req_type)
      REQ_REG: begin
        if (fin.size == '0) begin
          st_next = ST_ZERO_SIZE;
        end else if (is_legacy_req && legacy_present) begin
          st_next = ST_PRESENT;
        end else if (fin.hit) begin
          st_next   = ST_PRESENT;
          port_next = fin.res_port;
        end else if (over_req && is_legacy_req) begin
          st_next = ST_LEGACY_NOSP;
        end else if (over_req && over_fb) begin
          st_next = ST_TOO_BIG;
        end else if (count >= CNT_W'(NUM_RANGES)) begin
          st_next = ST_FULL;
        end else begin
          // Append, shrunk to the fallback size when space runs short.
          tbl_wr.en = fin_drain;
          if (over_req) begin
            tbl_wr.size = FALLBACK_SIZE;
          end
          port_next = fin.alloc[PORT_W-1:0];
        end
      end
      REQ_P2A: begin
        if (fin.hit && fin.pio <= port_limit) begin
          found_next = 1'b1;
          addr_next  = fin.res_addr;
        end
      end
      REQ_A2P: begin
        found_next = fin.hit;
        port_next  = fin.hit ? fin.res_port : '1;
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // Commit the entry count and legacy flag with the table write.
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      legacy_present <= 1'b0;
    end else if (tbl_wr.en) begin
      count <= count + CNT_W'(1);
      if (is_legacy_req) begin
        legacy_present <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_drain) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_drain) begin
      status   <= st_next;
      found    <= found_next;
      addr_out <= addr_next;
      port_out <= port_next;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!fin.valid && !tok[0].valid))
    else $error("token in flight while idle");

  a_launch: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (tok[0].valid && busy))
    else $error("accepted request did not launch a token");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_RANGES))
    else $error("entry count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (count < CNT_W'(NUM_RANGES) && fin_drain))
    else $error("table write without room or outside drain");

  a_drain_result: assert property (@(posedge clk) disable iff (rst)
    fin_drain |=> rsp_valid)
    else $error("finished request produced no result");

endmodule
